// ===== rtl/core/rltt_pkg.sv =====
// shared types and constants of the redo log transaction tracker
// no dependencies
package rltt_pkg;

  localparam int ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = 5'd31;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OP   = 1'b1;

  localparam int LOG_AREA_W = 7;
  localparam int MAX_OP_W   = 5;
  localparam logic [LOG_AREA_W-1:0] LOG_AREA_RESET = 7'd31;
  localparam logic [MAX_OP_W-1:0]   MAX_OP_RESET   = 5'd10;

  localparam int BLOCK_W = 32;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_WAIT     = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_OUTSIDE  = 3'd3,
    STAT_NO_BEGIN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

  typedef enum logic [1:0] {
    PTR_ZERO = 2'd0,
    PTR_HOLD = 2'd1,
    PTR_NEXT = 2'd2
  } ptr_sel_e;

  typedef struct packed {
    logic     accept;
    ptr_sel_e ptr_sel;
    logic     inc_active;
    logic     dec_active;
    logic     append;
    logic     clear_count;
    logic     out_load;
    logic     out_commit;
    status_e  out_status;
    logic     out_added;
    logic     out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic begin_ok;
    logic active_zero;
    logic end_commit;
    logic write_full;
    logic search_hit;
    logic search_end;
    logic commit_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/redo_log_transaction_tracker_unit.sv =====
// redo log transaction tracker: one word in at a time, results out through a register
// begin, end and refused words: result registered in the cycle after acceptance
// log write: logged table entries compared one per cycle, stopping at a hit or after the last one
// last end: one commit word per cycle while the result register frees, one per logged entry
// next word is taken once the previous one is finished and its result register frees
// reset clears counters and restores register defaults; the table needs no clearing
module redo_log_transaction_tracker_unit import rltt_pkg::*; #(
  parameter int LOG_CAPACITY = 30,
  localparam int IDX_W = $clog2(LOG_CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       in_operation_i,
  input  logic [BLOCK_W-1:0]    in_block_number_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_status_o,
  output logic                  out_newly_added_o,
  output logic                  out_commit_valid_o,
  output logic [BLOCK_W-1:0]    out_commit_block_o,
  output logic [IDX_W-1:0]      out_commit_slot_o,
  output logic                  out_last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rltt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_operation_i (in_operation_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  rltt_dp #(
    .LOG_CAPACITY (LOG_CAPACITY)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_block_number_i  (in_block_number_i),
    .out_ready_i        (out_ready_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_newly_added_o  (out_newly_added_o),
    .out_commit_valid_o (out_commit_valid_o),
    .out_commit_block_o (out_commit_block_o),
    .out_commit_slot_o  (out_commit_slot_o),
    .out_last_o         (out_last_o)
  );

endmodule

// ===== rtl/core/rltt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rltt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rltt_ctrl.sv =====
// controller state machine: sequences begin, end, log write and commit run
// depends on rltt_pkg
module rltt_ctrl import rltt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] in_operation_i,
  input  dp_stat_t        stat_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation_i == OP_END && !stat_i.active_zero && stat_i.end_commit) begin
            state_d = ST_COMMIT;
          end else if (in_operation_i == OP_WRITE && !stat_i.write_full &&
                       !stat_i.active_zero) begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (stat_i.search_hit || stat_i.search_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        if (stat_i.out_free && stat_i.commit_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.ptr_sel    = PTR_ZERO;
    cmd_o.out_status = STAT_OK;
    cmd_o.accept     = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.out_last = 1'b1;
          unique case (in_operation_i)
            OP_BEGIN: begin
              cmd_o.out_load   = 1'b1;
              cmd_o.inc_active = stat_i.begin_ok;
              cmd_o.out_status = stat_i.begin_ok ? STAT_OK : STAT_WAIT;
            end
            OP_END: begin
              if (stat_i.active_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STAT_NO_BEGIN;
              end else begin
                cmd_o.dec_active = 1'b1;
                cmd_o.out_load   = !stat_i.end_commit;
              end
            end
            OP_WRITE: begin
              if (stat_i.write_full) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STAT_TOO_BIG;
              end else if (stat_i.active_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STAT_OUTSIDE;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        cmd_o.out_last = 1'b1;
        priority if (stat_i.search_hit) begin
          cmd_o.out_load = 1'b1;
        end else if (stat_i.search_end) begin
          cmd_o.append    = 1'b1;
          cmd_o.out_load  = 1'b1;
          cmd_o.out_added = 1'b1;
        end else begin
          cmd_o.ptr_sel = PTR_NEXT;
        end
      end
      ST_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_commit  = 1'b1;
          cmd_o.out_last    = stat_i.commit_end;
          cmd_o.clear_count = stat_i.commit_end;
          cmd_o.ptr_sel     = stat_i.commit_end ? PTR_ZERO : PTR_NEXT;
        end else begin
          cmd_o.ptr_sel = PTR_HOLD;
        end
      end
      default: begin
        cmd_o.ptr_sel = PTR_ZERO;
      end
    endcase
  end

endmodule

// ===== rtl/core/rltt_dp.sv =====
// datapath: counters, config registers, block table, output word register
// depends on rltt_pkg and rltt_ram
module rltt_dp import rltt_pkg::*; #(
  parameter int LOG_CAPACITY = 30,
  localparam int IDX_W = $clog2(LOG_CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [BLOCK_W-1:0]    in_block_number_i,
  input  logic                  out_ready_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output logic                  out_valid_o,
  output logic [2:0]            out_status_o,
  output logic                  out_newly_added_o,
  output logic                  out_commit_valid_o,
  output logic [BLOCK_W-1:0]    out_commit_block_o,
  output logic [IDX_W-1:0]      out_commit_slot_o,
  output logic                  out_last_o
);

  localparam int CNT_W  = $clog2(LOG_CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > LOG_AREA_W) ? CNT_W : LOG_AREA_W) + 1;
  localparam int PROD_W = ACTIVE_W + 1 + MAX_OP_W;
  localparam int NEED_W = ((CNT_W > PROD_W) ? CNT_W : PROD_W) + 1;

  logic [LOG_AREA_W-1:0] log_area_q;
  logic [MAX_OP_W-1:0]   max_op_q;
  logic [CNT_W-1:0]      count_q;
  logic [ACTIVE_W-1:0]   active_q;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [BLOCK_W-1:0]    blk_q;
  logic [BLOCK_W-1:0]    rdata;
  logic [ACTIVE_W:0]     active_p1;
  logic [NEED_W-1:0]     need;
  logic [CNT_W-1:0]      ptr_p1;

  logic                  out_valid_q;
  logic [2:0]            out_status_q;
  logic                  out_added_q;
  logic                  out_cvalid_q;
  logic [BLOCK_W-1:0]    out_block_q;
  logic [IDX_W-1:0]      out_slot_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_area_q <= LOG_AREA_RESET;
      max_op_q   <= MAX_OP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOG_AREA: log_area_q <= cfg_wdata_i[LOG_AREA_W-1:0];
        CFG_MAX_OP:   max_op_q   <= cfg_wdata_i[MAX_OP_W-1:0];
        default:      log_area_q <= log_area_q;
      endcase
    end
  end

  // space check for begin
  assign active_p1 = (ACTIVE_W+1)'(active_q) + (ACTIVE_W+1)'(1);
  assign need      = NEED_W'(count_q) + NEED_W'(active_p1) * NEED_W'(max_op_q);
  assign ptr_p1    = CNT_W'(ptr_q) + CNT_W'(1);

  assign stat_o.begin_ok    = (active_q != ACTIVE_MAX) && (need <= NEED_W'(LOG_CAPACITY));
  assign stat_o.active_zero = (active_q == '0);
  assign stat_o.end_commit  = (active_q == ACTIVE_W'(1)) && (count_q != '0);
  assign stat_o.write_full  = (count_q >= CNT_W'(LOG_CAPACITY)) ||
                              (CMP_W'(count_q) + CMP_W'(1) >= CMP_W'(log_area_q));
  assign stat_o.search_hit  = (count_q != '0) && (rdata == blk_q);
  assign stat_o.search_end  = (count_q == '0) || (ptr_p1 == count_q);
  assign stat_o.commit_end  = (ptr_p1 == count_q);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.ptr_sel)
      PTR_ZERO: ptr_d = '0;
      PTR_HOLD: ptr_d = ptr_q;
      PTR_NEXT: ptr_d = ptr_q + IDX_W'(1);
      default:  ptr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= '0;
      ptr_q    <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.clear_count) begin
        count_q <= '0;
      end else if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.inc_active) begin
        active_q <= active_q + ACTIVE_W'(1);
      end else if (cmd_i.dec_active) begin
        active_q <= active_q - ACTIVE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q <= in_block_number_i;
    end
  end

  rltt_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (LOG_CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (blk_q),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_added_q  <= cmd_i.out_added;
      out_cvalid_q <= cmd_i.out_commit;
      out_block_q  <= cmd_i.out_commit ? rdata : '0;
      out_slot_q   <= cmd_i.out_commit ? ptr_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_newly_added_o  = out_added_q;
  assign out_commit_valid_o = out_cvalid_q;
  assign out_commit_block_o = out_block_q;
  assign out_commit_slot_o  = out_slot_q;
  assign out_last_o         = out_last_q;

endmodule
